### hdl/lfu_cache_with_lru_tiebreak_top_defines.svh
// Assertion macros used by the cache datapath (lfu_dp).
`ifndef LFU_CACHE_WITH_LRU_TIEBREAK_TOP_DEFINES_SVH
`define LFU_CACHE_WITH_LRU_TIEBREAK_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define LFU_ASSERT_IMP(lbl, clk, rstn, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
        else $error("assertion failed");
`define LFU_ASSERT_NXT(lbl, clk, rstn, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
        else $error("assertion failed");
`else
`define LFU_ASSERT_IMP(lbl, clk, rstn, pre, post)
`define LFU_ASSERT_NXT(lbl, clk, rstn, pre, post)
`endif
`endif

### hdl/lfu_pkg.sv
// Package with the types, constants and selection function of the cache.
`timescale 1ns / 1ps
package lfu_pkg;
    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int RANK_W   = IDX_W;
    localparam int THR_W    = IDX_W + 1;
    localparam int CAP_W    = 5;
    localparam int KEY_W    = 32;
    localparam int DATA_W   = 32;
    localparam int CNT_W    = 32;
    localparam int GRP_N    = 4;

    localparam logic REQ_GET = 1'b0;
    localparam logic REQ_PUT = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MATCH,
        S_SELECT,
        S_UPDATE
    } lfu_state_t;

    typedef struct packed {
        logic capture;
        logic match;
        logic select;
        logic update;
    } lfu_cmd_t;

    typedef struct packed {
        logic out_blocked;
    } lfu_stat_t;

    typedef struct packed {
        logic              vld;
        logic [CNT_W-1:0]  cnt;
        logic [RANK_W-1:0] rank;
        logic [IDX_W-1:0]  idx;
        logic [KEY_W-1:0]  key;
    } lfu_cand_t;

    // Returns the better eviction candidate: lower count, then older rank.
    function automatic lfu_cand_t lfu_pick(input lfu_cand_t a, input lfu_cand_t b);
        lfu_cand_t r;
        r = a;
        if (!a.vld)
        begin
            r = b;
        end
        else if (b.vld && ((b.cnt < a.cnt) || ((b.cnt == a.cnt) && (b.rank > a.rank))))
        begin
            r = b;
        end
        return r;
    endfunction
endpackage

### hdl/lfu_ctrl.sv
// Request sequencer of the cache: capture, match, select, update.
`timescale 1ns / 1ps
module lfu_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  lfu_pkg::lfu_stat_t stat,
    output lfu_pkg::lfu_cmd_t  cmd,
    output logic              in_stall
);
    import lfu_pkg::*;

    lfu_state_t state_reg;
    lfu_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_MATCH;
                end
            end
            S_MATCH:  state_next = S_SELECT;
            S_SELECT: state_next = S_UPDATE;
            S_UPDATE:
            begin
                if (!stat.out_blocked)
                begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                in_stall    = 1'b0;
                cmd.capture = in_valid;
            end
            S_MATCH:  cmd.match  = 1'b1;
            S_SELECT: cmd.select = 1'b1;
            S_UPDATE: cmd.update = !stat.out_blocked;
            default:  cmd = '0;
        endcase
    end
endmodule

### hdl/lfu_dp.sv
// Entry storage, key compare, victim tree and update lanes of the cache.
`timescale 1ns / 1ps
`include "lfu_cache_with_lru_tiebreak_top_defines.svh"
module lfu_dp
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  lfu_pkg::lfu_cmd_t            cmd,
    output lfu_pkg::lfu_stat_t           stat,
    input  logic [lfu_pkg::CAP_W-1:0]    cap,
    input  logic                         req_type,
    input  logic [lfu_pkg::KEY_W-1:0]    key,
    input  logic signed [lfu_pkg::DATA_W-1:0] value,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic                         hit,
    output logic signed [lfu_pkg::DATA_W-1:0] read_value,
    output logic                         evicted,
    output logic [lfu_pkg::KEY_W-1:0]    evicted_key
);
    import lfu_pkg::*;

    localparam int GRP_SZ = CAPACITY / GRP_N;

    // Entry store.
    logic [CAPACITY-1:0] valid_reg;
    logic [KEY_W-1:0]    key_reg  [CAPACITY];
    logic [DATA_W-1:0]   data_reg [CAPACITY];
    logic [CNT_W-1:0]    cnt_reg  [CAPACITY];
    logic [RANK_W-1:0]   rank_reg [CAPACITY];

    // Request being processed.
    logic               req_reg;
    logic [KEY_W-1:0]   rkey_reg;
    logic [DATA_W-1:0]  rval_reg;

    // Match stage results.
    logic [CAPACITY-1:0] match_reg;
    logic                hit_reg;
    logic [RANK_W-1:0]   frank_reg;
    logic [DATA_W-1:0]   fdata_reg;
    logic [CAP_W-1:0]    occ_reg;
    lfu_cand_t           grp_reg [GRP_N];

    // Select stage results.
    lfu_cand_t           vic_reg;
    logic [IDX_W-1:0]    free_reg;
    logic                bump_reg;
    logic                insert_reg;
    logic                evict_reg;

    // Output register.
    logic                out_valid_reg;
    logic                hit_o_reg;
    logic [DATA_W-1:0]   rd_o_reg;
    logic                ev_o_reg;
    logic [KEY_W-1:0]    evk_o_reg;

    logic [CAPACITY-1:0] match_v;
    logic [RANK_W-1:0]   frank_v;
    logic [DATA_W-1:0]   fdata_v;
    lfu_cand_t           cand   [CAPACITY];
    lfu_cand_t           grp_v  [GRP_N];
    lfu_cand_t           vic_v;
    logic [IDX_W-1:0]    free_v;
    logic [CAP_W-1:0]    cap_eff;
    logic                ins_v;
    logic [THR_W-1:0]    thr;
    logic [CAPACITY-1:0] target;

    assign cap_eff = (cap > CAP_W'(CAPACITY)) ? CAP_W'(CAPACITY) : cap;

    // Parallel key compare, one-hot read of the matching entry and the first level of the victim tree.
    always_comb
    begin
        frank_v = '0;
        fdata_v = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            match_v[i] = valid_reg[i] && (key_reg[i] == rkey_reg);
            frank_v    = frank_v | (match_v[i] ? rank_reg[i] : '0);
            fdata_v    = fdata_v | (match_v[i] ? data_reg[i] : '0);
            cand[i].vld  = valid_reg[i];
            cand[i].cnt  = cnt_reg[i];
            cand[i].rank = rank_reg[i];
            cand[i].idx  = IDX_W'(i);
            cand[i].key  = key_reg[i];
        end
        for (int g = 0; g < GRP_N; g++)
        begin
            grp_v[g] = cand[g*GRP_SZ];
            for (int j = 1; j < GRP_SZ; j++)
            begin
                grp_v[g] = lfu_pick(grp_v[g], cand[g*GRP_SZ + j]);
            end
        end
    end

    // Second tree level, the lowest free slot and the insert decision.
    always_comb
    begin
        vic_v  = grp_reg[0];
        for (int g = 1; g < GRP_N; g++)
        begin
            vic_v = lfu_pick(vic_v, grp_reg[g]);
        end
        free_v = '0;
        for (int i = CAPACITY - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_v = IDX_W'(i);
            end
        end
        ins_v = (req_reg == REQ_PUT) && (cap_eff != '0) && !hit_reg;
    end

    // Ranks below the threshold age by one; the target slot becomes newest.
    always_comb
    begin
        if (bump_reg)
        begin
            thr    = {1'b0, frank_reg};
            target = match_reg;
        end
        else if (evict_reg)
        begin
            thr    = {1'b0, vic_reg.rank};
            target = CAPACITY'(1) << vic_reg.idx;
        end
        else
        begin
            thr    = THR_W'(CAPACITY);
            target = CAPACITY'(1) << free_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg  <= req_type;
            rkey_reg <= key;
            rval_reg <= value;
        end
        if (cmd.match)
        begin
            match_reg <= match_v;
            hit_reg   <= |match_v;
            frank_reg <= frank_v;
            fdata_reg <= fdata_v;
            occ_reg   <= CAP_W'($countones(valid_reg));
            grp_reg   <= grp_v;
        end
        if (cmd.select)
        begin
            vic_reg    <= vic_v;
            free_reg   <= free_v;
            insert_reg <= ins_v;
            evict_reg  <= ins_v && (occ_reg >= cap_eff);
            bump_reg   <= hit_reg && ((req_reg == REQ_GET) || (cap_eff != '0));
        end
        if (cmd.update)
        begin
            hit_o_reg <= hit_reg;
            rd_o_reg  <= ((req_reg == REQ_GET) && hit_reg) ? fdata_reg : '0;
            ev_o_reg  <= evict_reg;
            evk_o_reg <= evict_reg ? vic_reg.key : '0;
            if (bump_reg || insert_reg)
            begin
                for (int i = 0; i < CAPACITY; i++)
                begin
                    if (target[i])
                    begin
                        rank_reg[i] <= '0;
                        if (insert_reg)
                        begin
                            key_reg[i]  <= rkey_reg;
                            data_reg[i] <= rval_reg;
                            cnt_reg[i]  <= CNT_W'(1);
                        end
                        else
                        begin
                            if (req_reg == REQ_PUT)
                            begin
                                data_reg[i] <= rval_reg;
                            end
                            if (cnt_reg[i] != '1)
                            begin
                                cnt_reg[i] <= cnt_reg[i] + CNT_W'(1);
                            end
                        end
                    end
                    else if (valid_reg[i] && ({1'b0, rank_reg[i]} < thr))
                    begin
                        rank_reg[i] <= rank_reg[i] + RANK_W'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.update)
            begin
                out_valid_reg <= 1'b1;
                if (insert_reg)
                begin
                    valid_reg <= valid_reg | target;
                end
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.out_blocked = out_valid_reg && out_stall;
    assign out_valid   = out_valid_reg;
    assign hit         = hit_o_reg;
    assign read_value  = rd_o_reg;
    assign evicted     = ev_o_reg;
    assign evicted_key = evk_o_reg;

    `LFU_ASSERT_IMP(a_evict_has_victim, clk, rst_n, cmd.update && evict_reg, vic_reg.vld)
    `LFU_ASSERT_IMP(a_hit_single, clk, rst_n, cmd.select && hit_reg, $onehot(match_reg))
    `LFU_ASSERT_NXT(a_update_shows, clk, rst_n, cmd.update, out_valid_reg)
endmodule

### hdl/lfu_cache_with_lru_tiebreak_top.sv
// Top level of the least-frequently-used cache with recency tiebreak.
`timescale 1ns / 1ps
// The block is a fully associative key/value cache of sixteen entries.
// A request transaction on the input channel (in_valid, in_stall) carries
// req_type (get or put), key and value. Each request yields exactly one
// result transaction on the output channel (out_valid, out_stall) carrying
// hit, read_value, evicted and evicted_key.
// A request passes through capture, key compare plus the first level of the
// victim tree, the second tree level plus free-slot search, and the entry
// update that also loads the output register. Because of the two-level
// victim tree and the serial dependence between requests, a new request is
// taken only after the previous one has passed its entry update.
// If the receiver stalls, the result waits in the output register; the next
// request is still taken, but its update step holds, with in_stall high,
// until the waiting result is taken.
// capacity_in_use is written through cfg_valid/cfg_data, always ready; it
// should only be changed while the block is idle.
// Reset empties the cache and sets capacity_in_use to sixteen.
module lfu_cache_with_lru_tiebreak_top
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              req_type,
    input  logic [lfu_pkg::KEY_W-1:0]         key,
    input  logic signed [lfu_pkg::DATA_W-1:0] value,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              hit,
    output logic signed [lfu_pkg::DATA_W-1:0] read_value,
    output logic                              evicted,
    output logic [lfu_pkg::KEY_W-1:0]         evicted_key,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [lfu_pkg::CAP_W-1:0]         cfg_data
);
    import lfu_pkg::*;

    lfu_cmd_t         cmd;
    lfu_stat_t        stat;
    logic [CAP_W-1:0] cap_reg;

    // The capacity register accepts a write in every cycle.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_W'(CAPACITY);
        end
        else if (cfg_valid && cfg_ready)
        begin
            cap_reg <= cfg_data;
        end
    end

    lfu_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .stat     (stat),
        .cmd      (cmd),
        .in_stall (in_stall)
    );

    lfu_dp u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .cap         (cap_reg),
        .req_type    (req_type),
        .key         (key),
        .value       (value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .hit         (hit),
        .read_value  (read_value),
        .evicted     (evicted),
        .evicted_key (evicted_key)
    );
endmodule

### sim/tb_lfu_cache_with_lru_tiebreak_top.sv
// Testbench for the LFU cache with LRU tiebreak: predicts and checks every result.
`timescale 1ns / 1ps

// Scoreboard: holds a copy of the cache state and a queue of predicted results.
class lfu_scoreboard;
    typedef struct packed {
        logic        hit;
        logic [31:0] read_value;
        logic        evicted;
        logic [31:0] evicted_key;
    } lfu_result_t;

    bit          slot_valid [lfu_pkg::CAPACITY];
    bit [31:0]   slot_key   [lfu_pkg::CAPACITY];
    bit [31:0]   slot_data  [lfu_pkg::CAPACITY];
    bit [31:0]   slot_count [lfu_pkg::CAPACITY];
    int unsigned slot_rank  [lfu_pkg::CAPACITY];
    bit [4:0]    capacity;
    lfu_result_t pending_results[$];
    int          mismatches;
    int          checked;
    int          hits_seen;
    int          evictions_seen;

    function new();
        for (int i = 0; i < lfu_pkg::CAPACITY; i++)
        begin
            slot_valid[i] = 0;
            slot_key[i] = 0;
            slot_data[i] = 0;
            slot_count[i] = 0;
            slot_rank[i] = 0;
        end
        capacity = 5'd16;
        mismatches = 0;
        checked = 0;
        hits_seen = 0;
        evictions_seen = 0;
    endfunction

    function void set_capacity(bit [4:0] c);
        capacity = c;
    endfunction

    function void promote(int s);
        int unsigned r;
        r = slot_rank[s];
        for (int i = 0; i < lfu_pkg::CAPACITY; i++)
            if (slot_valid[i] && slot_rank[i] < r)
                slot_rank[i]++;
        slot_rank[s] = 0;
    endfunction

    function void touch(int s);
        if (slot_count[s] != 32'hFFFF_FFFF)
            slot_count[s]++;
        promote(s);
    endfunction

    // Notes an accepted request and queues the result it should produce.
    function void note_request(bit is_put, bit [31:0] k, bit [31:0] v);
        lfu_result_t res;
        int unsigned cap;
        int unsigned occupied;
        int found;
        int slot;
        int victim;
        int unsigned vr;
        res = '0;
        cap = (capacity > lfu_pkg::CAPACITY) ? lfu_pkg::CAPACITY : capacity;
        occupied = 0;
        found = -1;
        for (int i = 0; i < lfu_pkg::CAPACITY; i++)
            if (slot_valid[i])
            begin
                occupied++;
                if (found < 0 && slot_key[i] == k)
                    found = i;
            end
        res.hit = (found >= 0);
        if (is_put == lfu_pkg::REQ_GET)
        begin
            if (found >= 0)
            begin
                res.read_value = slot_data[found];
                touch(found);
            end
        end
        else if (cap != 0)
        begin
            if (found >= 0)
            begin
                slot_data[found] = v;
                touch(found);
            end
            else
            begin
                slot = -1;
                if (occupied >= cap)
                begin
                    victim = -1;
                    for (int i = 0; i < lfu_pkg::CAPACITY; i++)
                    begin
                        if (!slot_valid[i])
                            continue;
                        if (victim < 0 || slot_count[i] < slot_count[victim] ||
                            (slot_count[i] == slot_count[victim] &&
                             slot_rank[i] > slot_rank[victim]))
                            victim = i;
                    end
                    if (victim >= 0)
                    begin
                        vr = slot_rank[victim];
                        res.evicted = 1;
                        res.evicted_key = slot_key[victim];
                        slot_valid[victim] = 0;
                        for (int i = 0; i < lfu_pkg::CAPACITY; i++)
                            if (slot_valid[i] && slot_rank[i] > vr)
                                slot_rank[i]--;
                        slot = victim;
                    end
                end
                if (slot < 0)
                    for (int i = 0; i < lfu_pkg::CAPACITY; i++)
                        if (!slot_valid[i])
                        begin
                            slot = i;
                            break;
                        end
                if (slot >= 0)
                begin
                    for (int i = 0; i < lfu_pkg::CAPACITY; i++)
                        if (slot_valid[i])
                            slot_rank[i]++;
                    slot_valid[slot] = 1;
                    slot_key[slot] = k;
                    slot_data[slot] = v;
                    slot_count[slot] = 1;
                    slot_rank[slot] = 0;
                end
            end
        end
        pending_results.push_back(res);
    endfunction

    // Compares one accepted result with the oldest prediction.
    function void check_result(logic h, logic [31:0] rv, logic e, logic [31:0] ek);
        lfu_result_t want;
        checked++;
        if (pending_results.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("ERROR: result with no request pending (hit=%0b)", h);
            return;
        end
        want = pending_results.pop_front();
        if (want.hit) hits_seen++;
        if (want.evicted) evictions_seen++;
        if (h !== want.hit || rv !== want.read_value || e !== want.evicted ||
            ek !== want.evicted_key)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display({"ERROR: expected hit=%0b rd=%h ev=%0b evk=%h, ",
                          "got hit=%0b rd=%h ev=%0b evk=%h"},
                         want.hit, want.read_value, want.evicted, want.evicted_key,
                         h, rv, e, ek);
        end
    endfunction
endclass

module tb_lfu_cache_with_lru_tiebreak_top;
    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        req_type;
    logic [31:0] key;
    logic signed [31:0] value;
    logic        out_valid;
    logic        out_stall;
    logic        hit;
    logic signed [31:0] read_value;
    logic        evicted;
    logic [31:0] evicted_key;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [4:0]  cfg_data;

    lfu_scoreboard board;
    int          items_sent;
    bit          stimulus_done;
    // Keys are drawn from a small pool most of the time so that hits,
    // updates and evictions are frequent; the pool holds the extremes too.
    bit [31:0]   key_pool[24];

    lfu_cache_with_lru_tiebreak_top DUT
    (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .req_type(req_type),
        .key(key),
        .value(value),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .hit(hit),
        .read_value(read_value),
        .evicted(evicted),
        .evicted_key(evicted_key),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    initial clk = 0;
    always #5 clk = ~clk;

    // Sends one request transaction, after a random idle gap unless no_gap is set.
    // Inputs change on the falling edge; acceptance is judged at the rising edge.
    // Valid is dropped with a blocking assignment so that a request sent
    // with no gap can raise it again in the same time step.
    task automatic send_request(bit is_put, bit [31:0] k, bit [31:0] v, bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 13);
        repeat (gap) @(negedge clk);
        in_valid <= 1;
        req_type <= is_put;
        key <= k;
        value <= v;
        forever
        begin
            @(posedge clk);
            if (!in_stall)
                break;
        end
        board.note_request(is_put, k, v);
        items_sent++;
        @(negedge clk);
        in_valid = 0;
    endtask

    // Writes capacity_in_use once every prediction has been drained.
    task automatic write_capacity(bit [4:0] c);
        while (board.pending_results.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
        cfg_valid <= 1;
        cfg_data <= c;
        forever
        begin
            @(posedge clk);
            if (cfg_ready)
                break;
        end
        board.set_capacity(c);
        @(negedge clk);
        cfg_valid <= 0;
    endtask

    function automatic bit [31:0] pick_key();
        if ($urandom_range(0, 9) == 0)
            return $urandom;
        return key_pool[$urandom_range(0, 23)];
    endfunction

    // Receiver: stalls for a random stretch per result, sometimes not at all.
    // out_stall only changes on the falling edge.
    initial
    begin : receiver
        int wait_cycles;
        out_stall = 1;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            wait_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
            if (wait_cycles > 0)
            begin
                out_stall <= 1;
                repeat (wait_cycles) @(negedge clk);
            end
            out_stall <= 0;
            forever
            begin
                @(posedge clk);
                if (out_valid)
                    break;
            end
            board.check_result(hit, read_value, evicted, evicted_key);
        end
    end

    // Main stimulus: directed cases, then random phases at several capacities.
    initial
    begin : stimulus
        bit [4:0] caps[7];
        int burst;
        board = new();
        items_sent = 0;
        stimulus_done = 0;
        in_valid = 0;
        req_type = 0;
        key = 0;
        value = 0;
        cfg_valid = 0;
        cfg_data = 0;
        rst_n = 0;
        for (int i = 0; i < 24; i++)
            key_pool[i] = $urandom;
        key_pool[0] = 32'h0000_0000;
        key_pool[1] = 32'hFFFF_FFFF;
        key_pool[2] = 32'h8000_0000;
        key_pool[3] = 32'h7FFF_FFFF;
        repeat (10) @(negedge clk);
        rst_n = 1;
        repeat (2) @(negedge clk);

        // Directed: miss on an empty cache, extreme keys and values, update,
        // get hits, then capacity two so that LFU eviction shows.
        send_request(lfu_pkg::REQ_GET, 32'h0, 32'h0, 1);
        send_request(lfu_pkg::REQ_PUT, 32'h0, 32'h8000_0000, 0);
        send_request(lfu_pkg::REQ_PUT, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 0);
        send_request(lfu_pkg::REQ_GET, 32'hFFFF_FFFF, 32'h1234_5678, 0);
        send_request(lfu_pkg::REQ_PUT, 32'h0, 32'hFFFF_FFFF, 0);
        send_request(lfu_pkg::REQ_GET, 32'h0, 32'h0, 0);
        write_capacity(2);
        // Entries at counts three and two; each new key evicts the least used one.
        send_request(lfu_pkg::REQ_PUT, 32'h5, 32'h5, 0);
        send_request(lfu_pkg::REQ_PUT, 32'h6, 32'h6, 0);
        send_request(lfu_pkg::REQ_GET, 32'h6, 32'h0, 0);
        // Zero capacity: puts do nothing, even to a present key, gets still hit.
        write_capacity(0);
        send_request(lfu_pkg::REQ_PUT, 32'h6, 32'hDEAD_BEEF, 0);
        send_request(lfu_pkg::REQ_PUT, 32'h77, 32'h1, 0);
        send_request(lfu_pkg::REQ_GET, 32'h6, 32'h0, 0);
        // Capacity above the entry count acts as the full size.
        write_capacity(31);
        for (int i = 0; i < 18; i++)
            send_request(lfu_pkg::REQ_PUT, 32'h100 + i, $urandom, i[0]);

        // Random phases; capacities below the occupancy show puts evicting without growing the cache.
        caps = '{5'd16, 5'd1, 5'd7, 5'd0, 5'd31, 5'd3, 5'd16};
        foreach (caps[p])
        begin
            write_capacity(caps[p]);
            for (int n = 0; n < 160; n++)
            begin
                burst = ($urandom_range(0, 5) == 0);
                send_request(1'($urandom_range(0, 1)), pick_key(), $urandom, burst[0]);
            end
        end
        stimulus_done = 1;
    end

    // Completion check: waits for every predicted result, then a drain time.
    initial
    begin : finisher
        wait (stimulus_done);
        while (board.pending_results.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
        $display("Covered %0d requests, %0d results checked, %0d hits, %0d evictions.",
                 items_sent, board.checked, board.hits_seen, board.evictions_seen);
        $display("Capacities 0, 1, 2, 3, 7, 16 and 31 were exercised with random stalls.");
        if (board.mismatches == 0 && board.pending_results.size() == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("%0d mismatches", board.mismatches);
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run of about 1200 items.
    initial
    begin : watchdog
        #5_000_000;
        $display("Timeout");
        $display("CHECK FAILED");
        $finish;
    end
endmodule
